>>> design/multi_list_store_defines.svh
// Assertion macros for the multi-list store.
`ifndef MULTI_LIST_STORE_DEFINES_SVH
`define MULTI_LIST_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLS_ASSERT(label, clk, rst_n, prop, msg)
`define MLS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> design/mls_pkg.sv
// Shared types and constants for the multi-list store.
package mls_pkg;
  localparam int NumListsDef = 8;
  localparam int ListCapDef  = 8;

  localparam logic [3:0] ACT_CREATE   = 4'd0;
  localparam logic [3:0] ACT_APPEND   = 4'd1;
  localparam logic [3:0] ACT_DROP     = 4'd2;
  localparam logic [3:0] ACT_DELETE   = 4'd3;
  localparam logic [3:0] ACT_READ     = 4'd4;
  localparam logic [3:0] ACT_READ_SRT = 4'd5;
  localparam logic [3:0] ACT_RESIZE   = 4'd6;
  localparam logic [3:0] ACT_COUNT    = 4'd7;
  localparam logic [3:0] ACT_ALL      = 4'd8;
  localparam logic [3:0] ACT_ALL_SRT  = 4'd9;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_BAD_LIST     = 4'd1;
  localparam logic [3:0] ST_EXISTS       = 4'd2;
  localparam logic [3:0] ST_BAD_SIZE     = 4'd3;
  localparam logic [3:0] ST_NO_MEM       = 4'd4;
  localparam logic [3:0] ST_NO_LIST      = 4'd5;
  localparam logic [3:0] ST_FULL         = 4'd6;
  localparam logic [3:0] ST_EMPTY        = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND    = 4'd8;
  localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd9;
  localparam logic [3:0] ST_ALL_EMPTY    = 4'd10;

  // datapath commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_RD    = 3'd1;  // read element at list/pos
  localparam logic [2:0] CMD_WR    = 3'd2;  // write in value at list/pos
  localparam logic [2:0] CMD_SHIFT = 3'd3;  // write last read data at list/pos

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  list_number;
    logic [31:0] value;
    logic [5:0]  size_amount;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] data_value;
    logic        data_valid;
    logic [3:0]  element_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] list;
    logic [2:0] pos;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] rd_data;
  } dp_stat_t;
endpackage

>>> design/mls_if.sv
// Valid/ready channel interfaces for the multi-list store.
interface mls_in_if;
  logic              valid;
  logic              ready;
  mls_pkg::in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface mls_out_if;
  logic               valid;
  logic               ready;
  mls_pkg::out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

>>> design/mls_datapath.sv
// Element memory of the multi-list store with a registered read port.
module mls_datapath (
  input  logic             clk,
  input  logic [31:0]      wr_value,
  input  mls_pkg::dp_cmd_t cmd,
  output mls_pkg::dp_stat_t stat
);
  logic [31:0] mem [64];
  logic [31:0] rd_data_r;
  logic [5:0]  addr;

  assign addr = {cmd.list, cmd.pos};

  always_ff @(posedge clk) begin
    if (cmd.cmd == mls_pkg::CMD_WR) begin
      mem[addr] <= wr_value;
    end else if (cmd.cmd == mls_pkg::CMD_SHIFT) begin
      mem[addr] <= rd_data_r;
    end
    if (cmd.cmd == mls_pkg::CMD_RD) begin
      rd_data_r <= mem[addr];
    end
  end

  assign stat.rd_data = rd_data_r;
endmodule

>>> design/mls_ctrl.sv
// Command sequencer for the multi-list store: list table, gathering, sort and output.
module mls_ctrl #(
  parameter int NUM_LISTS     = mls_pkg::NumListsDef,
  parameter int LIST_CAPACITY = mls_pkg::ListCapDef
) (
  input  logic              clk,
  input  logic              rst_n,
  mls_in_if.sink            in_ch,
  mls_out_if.source         out_ch,
  output mls_pkg::dp_cmd_t  cmd,
  output logic [31:0]       wr_value,
  input  mls_pkg::dp_stat_t stat
);
  localparam int BufN = 64;
  localparam logic signed [6:0] LcS = 7'(LIST_CAPACITY);
  localparam logic [4:0] S_IDLE = 5'd0, S_DEC = 5'd1, S_SEND = 5'd2, S_DEL_RD = 5'd3,
    S_DEL_CHK = 5'd4, S_SH_RD = 5'd5, S_SH_WR = 5'd6, S_G_RD = 5'd7, S_G_WT = 5'd8,
    S_G_CAP = 5'd9, S_SORT_A = 5'd10, S_SORT_B = 5'd11, S_E_RD = 5'd12,
    S_SORT_C = 5'd13, S_SORT_K = 5'd14, S_SORT_W = 5'd15, S_E_OUT = 5'd16,
    S_E_FIN = 5'd17;

  logic [4:0]  state_r, state_nxt;
  logic [3:0]  cap_r  [8];
  logic [3:0]  fill_r [8];
  mls_pkg::in_word_t req_r;
  mls_pkg::out_word_t ow_r, ow_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] buf_r [BufN];
  logic [31:0] buf_rd_r;
  logic [6:0]  n_r, n_nxt;
  logic [2:0]  gl_r, gl_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [6:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [31:0] key_r, key_nxt;
  logic        all_r, all_nxt;

  logic        buf_we;
  logic [5:0]  buf_wa, buf_ra;
  logic [31:0] buf_wd;
  logic        cap_we, fill_we;
  logic [3:0]  cap_wd, fill_wd;

  logic [2:0]  li;
  logic [3:0]  cap, fill;
  logic signed [6:0] sz, ns;
  logic        bad_list, is_all, sorted_rd, app_ok;

  assign li        = 3'(req_r.list_number - 4'd1);
  assign bad_list  = (req_r.list_number == 4'd0) ||
                     (5'(req_r.list_number) > 5'(NUM_LISTS));
  assign cap       = cap_r[li];
  assign fill      = fill_r[li];
  assign sz        = {req_r.size_amount[5], req_r.size_amount};
  assign ns        = $signed({3'b000, cap}) + sz;
  assign is_all    = (req_r.action == mls_pkg::ACT_ALL) ||
                     (req_r.action == mls_pkg::ACT_ALL_SRT);
  assign sorted_rd = (req_r.action == mls_pkg::ACT_READ_SRT) ||
                     (req_r.action == mls_pkg::ACT_ALL_SRT);
  assign app_ok    = (fill < cap) && (fill < 4'(LIST_CAPACITY));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.word  = ow_r;
  assign wr_value     = req_r.value;

  always_comb begin
    cmd = '{cmd: mls_pkg::CMD_NONE, list: li, pos: pos_r[2:0]};
    unique case (state_r)
      S_DEC: begin
        if (req_r.action == mls_pkg::ACT_APPEND && !bad_list && cap != 4'd0 && app_ok) begin
          cmd.cmd = mls_pkg::CMD_WR;
          cmd.pos = fill[2:0];
        end
      end
      S_DEL_RD, S_SH_RD: begin
        cmd.cmd = mls_pkg::CMD_RD;
        if (state_r == S_SH_RD) cmd.pos = 3'(pos_r + 4'd1);
      end
      S_SH_WR: cmd.cmd = mls_pkg::CMD_SHIFT;
      S_G_RD: begin
        cmd.cmd  = mls_pkg::CMD_RD;
        cmd.list = gl_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ow_nxt    = ow_r;
    ov_nxt    = ov_r;
    n_nxt     = n_r;
    gl_nxt    = gl_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    key_nxt   = key_r;
    all_nxt   = all_r;
    buf_we    = 1'b0;
    buf_wa    = n_r[5:0];
    buf_wd    = buf_rd_r;
    buf_ra    = k_r[5:0];
    cap_we    = 1'b0;
    cap_wd    = cap;
    fill_we   = 1'b0;
    fill_wd   = fill;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_DEC;
      S_DEC: begin
        ow_nxt = '{status: mls_pkg::ST_OK, data_value: '0, data_valid: 1'b0,
                   element_count: '0, last: 1'b1};
        all_nxt   = is_all;
        state_nxt = S_SEND;
        if (req_r.action > mls_pkg::ACT_ALL_SRT) begin
          state_nxt = S_IDLE;
        end else if (is_all) begin
          n_nxt = '0; gl_nxt = '0; pos_nxt = '0;
          state_nxt = S_G_CAP;
        end else if (bad_list) begin
          ow_nxt.status = mls_pkg::ST_BAD_LIST;
        end else if (req_r.action == mls_pkg::ACT_CREATE) begin
          if (cap != 4'd0) ow_nxt.status = mls_pkg::ST_EXISTS;
          else if (sz < 7'sd1) ow_nxt.status = mls_pkg::ST_BAD_SIZE;
          else if (sz > LcS) ow_nxt.status = mls_pkg::ST_NO_MEM;
          else begin
            cap_we  = 1'b1;
            cap_wd  = req_r.size_amount[3:0];
            fill_we = 1'b1;
            fill_wd = '0;
          end
        end else if (cap == 4'd0) begin
          ow_nxt.status = mls_pkg::ST_NO_LIST;
        end else begin
          unique case (req_r.action)
            mls_pkg::ACT_APPEND:
              if (!app_ok) ow_nxt.status = mls_pkg::ST_FULL;
              else begin
                fill_we = 1'b1;
                fill_wd = fill + 4'd1;
              end
            mls_pkg::ACT_DROP:
              if (fill == 4'd0) ow_nxt.status = mls_pkg::ST_EMPTY;
              else begin
                fill_we = 1'b1;
                fill_wd = fill - 4'd1;
              end
            mls_pkg::ACT_DELETE:
              if (fill == 4'd0) ow_nxt.status = mls_pkg::ST_EMPTY;
              else begin
                pos_nxt   = '0;
                state_nxt = S_DEL_RD;
              end
            mls_pkg::ACT_READ, mls_pkg::ACT_READ_SRT: begin
              n_nxt = '0; gl_nxt = li; pos_nxt = '0;
              state_nxt = S_G_CAP;
            end
            mls_pkg::ACT_RESIZE:
              if (ns < 7'sd1) ow_nxt.status = mls_pkg::ST_BAD_NEW_SIZE;
              else if (ns > LcS) ow_nxt.status = mls_pkg::ST_NO_MEM;
              else begin
                cap_we = 1'b1;
                cap_wd = ns[3:0];
                if (fill > ns[3:0]) begin
                  fill_we = 1'b1;
                  fill_wd = ns[3:0];
                end
              end
            default:
              if (fill == 4'd0) ow_nxt.status = mls_pkg::ST_EMPTY;
              else ow_nxt.element_count = fill;
          endcase
        end
      end
      S_SEND: begin
        ov_nxt    = 1'b1;
        state_nxt = S_E_FIN;
      end
      S_DEL_RD: state_nxt = S_DEL_CHK;
      S_DEL_CHK: begin
        if (stat.rd_data == req_r.value) begin
          if (pos_r + 4'd1 < fill) state_nxt = S_SH_RD;
          else begin
            fill_we   = 1'b1;
            fill_wd   = fill - 4'd1;
            state_nxt = S_SEND;
          end
        end else if (pos_r + 4'd1 < fill) begin
          pos_nxt   = pos_r + 4'd1;
          state_nxt = S_DEL_RD;
        end else begin
          ow_nxt.status = mls_pkg::ST_NOT_FOUND;
          state_nxt     = S_SEND;
        end
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r + 4'd2 < fill) state_nxt = S_SH_RD;
        else begin
          fill_we   = 1'b1;
          fill_wd   = fill - 4'd1;
          state_nxt = S_SEND;
        end
      end
      // gather: check position against fill of list gl_r
      S_G_CAP: begin
        if (pos_r < fill_r[gl_r] && pos_r < 4'(LIST_CAPACITY)) state_nxt = S_G_RD;
        else if (all_r && 4'(gl_r) < 4'(NUM_LISTS - 1)) begin
          gl_nxt  = gl_r + 3'd1;
          pos_nxt = '0;
        end else if (n_r == 7'd0) begin
          if (all_r) ow_nxt.status = mls_pkg::ST_ALL_EMPTY;
          state_nxt = S_SEND;
        end else begin
          i_nxt     = 7'd1;
          state_nxt = sorted_rd ? S_SORT_A : S_SORT_C;
        end
      end
      S_G_RD: state_nxt = S_G_WT;
      S_G_WT: begin
        buf_we    = 1'b1;
        buf_wa    = n_r[5:0];
        buf_wd    = stat.rd_data;
        n_nxt     = n_r + 7'd1;
        pos_nxt   = pos_r + 4'd1;
        state_nxt = S_G_CAP;
      end
      // insertion sort over the buffer's registered read port
      S_SORT_A: begin
        if (i_r >= n_r) state_nxt = S_SORT_C;
        else begin
          buf_ra    = i_r[5:0];
          j_nxt     = i_r;
          state_nxt = S_SORT_K;
        end
      end
      S_SORT_K: begin
        key_nxt   = buf_rd_r;
        buf_ra    = 6'(j_r - 7'd1);
        state_nxt = S_SORT_B;
      end
      S_SORT_B: begin
        buf_ra = 6'(j_r - 7'd2);
        buf_we = 1'b1;
        buf_wa = j_r[5:0];
        if ($signed(buf_rd_r) > $signed(key_r)) begin
          buf_wd = buf_rd_r;
          j_nxt  = j_r - 7'd1;
          if (j_r == 7'd1) state_nxt = S_SORT_W;
        end else begin
          buf_wd    = key_r;
          i_nxt     = i_r + 7'd1;
          state_nxt = S_SORT_A;
        end
      end
      S_SORT_W: begin
        buf_we    = 1'b1;
        buf_wa    = j_r[5:0];
        buf_wd    = key_r;
        i_nxt     = i_r + 7'd1;
        state_nxt = S_SORT_A;
      end
      S_SORT_C: begin
        k_nxt     = '0;
        state_nxt = S_E_RD;
      end
      S_E_RD: state_nxt = S_E_OUT;
      S_E_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ow_nxt = '{status: mls_pkg::ST_OK, data_value: buf_rd_r, data_valid: 1'b1,
                     element_count: '0, last: (k_r + 7'd1 == n_r)};
          k_nxt  = k_r + 7'd1;
          state_nxt = (k_r + 7'd1 == n_r) ? S_E_FIN : S_E_RD;
        end
      end
      S_E_FIN: if (!ov_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int q = 0; q < 8; q++) begin
        cap_r[q]  <= '0;
        fill_r[q] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cap_we) cap_r[li] <= cap_wd;
      if (fill_we) fill_r[li] <= fill_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) req_r <= in_ch.word;
    ow_r  <= ow_nxt;
    n_r   <= n_nxt;
    gl_r  <= gl_nxt;
    pos_r <= pos_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    key_r <= key_nxt;
    all_r <= all_nxt;
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_r[buf_wa] <= buf_wd;
    buf_rd_r <= buf_r[buf_ra];
  end
endmodule

>>> design/multi_list_store.sv
// Multi-list store top level: controller and element memory.
// Simple commands go through decode and send; a delete reads and checks each element in turn,
// then shifts the later ones down. Reads gather element by element and visit each list; sorts
// add a key load per element and a step per move (insertion sort). Words go out once gathered.
// A new command is taken the cycle after the last word has been accepted.
// Reset (rst_n low, synchronous) clears all lists to not created; element memory is not cleared.
`include "multi_list_store_defines.svh"
module multi_list_store #(
  parameter int NUM_LISTS     = mls_pkg::NumListsDef,
  parameter int LIST_CAPACITY = mls_pkg::ListCapDef
) (
  input logic       clk,
  input logic       rst_n,
  mls_in_if.sink    in_ch,
  mls_out_if.source out_ch
);
  mls_pkg::dp_cmd_t  cmd;
  mls_pkg::dp_stat_t stat;
  logic [31:0]       wr_value;

  mls_ctrl #(.NUM_LISTS(NUM_LISTS), .LIST_CAPACITY(LIST_CAPACITY)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cmd, .wr_value, .stat
  );

  mls_datapath u_dp (.clk, .wr_value, .cmd, .stat);

  `MLS_ASSERT(a_out_valid_one, clk, rst_n, out_ch.valid |-> out_ch.word.data_valid || out_ch.word.last, "word without data must be last")
  `MLS_ASSERT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(out_ch.word), "stalled word changed")
  `MLS_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_ch.valid, "valid after reset")
endmodule

>>> sim/mls_tb_pkg.sv
// Testbench-side types for the multi-list store: pending command with its idle gap.
`timescale 1ns / 100ps
package mls_tb_pkg;
  typedef struct {
    mls_pkg::in_word_t word;
    int unsigned       wait_cycles;
  } pending_cmd_t;
endpackage

>>> sim/multi_list_store_test.sv
// Self-checking testbench for the multi-list store: random and directed commands, predicted answers.
`timescale 1ns / 100ps
module multi_list_store_test;
  localparam int NL = mls_pkg::NumListsDef;
  localparam int LC = mls_pkg::ListCapDef;
  localparam int unsigned HoldLen = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mls_in_if  in_ch();
  mls_out_if out_ch();

  multi_list_store i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  always #6 clk = ~clk;

  // predictor state
  int unsigned shadow_cap [NL];
  int unsigned shadow_fill [NL];
  logic [31:0] shadow_elem [NL][LC];

  mls_tb_pkg::pending_cmd_t cmd_queue[$];
  mls_pkg::out_word_t       answers_due[$];
  int unsigned  errors = 0;
  int unsigned  words_checked = 0;
  int unsigned  cmds_sent = 0;
  bit           hold_req = 1'b0;
  int unsigned  hold_count = 0;
  bit           in_taken = 1'b0;

  function automatic void push_answer(logic [3:0] st, logic [31:0] d, bit v,
                                      logic [3:0] c, bit f);
    mls_pkg::out_word_t w;
    w.status = st; w.data_value = d; w.data_valid = v; w.element_count = c; w.last = f;
    answers_due.push_back(w);
  endfunction

  function automatic void push_status(logic [3:0] st);
    push_answer(st, '0, 1'b0, 4'd0, 1'b1);
  endfunction

  function automatic void push_list(logic [31:0] buf_q[$], bit sorted);
    logic [31:0] t;
    int j;
    if (sorted)
      for (int i = 1; i < buf_q.size(); i++) begin
        t = buf_q[i];
        j = i - 1;
        while (j >= 0 && $signed(buf_q[j]) > $signed(t)) begin
          buf_q[j + 1] = buf_q[j];
          j--;
        end
        buf_q[j + 1] = t;
      end
    if (buf_q.size() == 0) push_status(mls_pkg::ST_OK);
    foreach (buf_q[k])
      push_answer(mls_pkg::ST_OK, buf_q[k], 1'b1, 4'd0, k == buf_q.size() - 1);
  endfunction

  function automatic void predict_store(mls_pkg::in_word_t w);
    logic [31:0] gather[$];
    int amt, li, fill, ns;
    bit hit;
    amt = int'($signed(w.size_amount));
    if (w.action > mls_pkg::ACT_ALL_SRT) return;
    if (w.action == mls_pkg::ACT_ALL || w.action == mls_pkg::ACT_ALL_SRT) begin
      for (int l = 0; l < NL; l++)
        for (int i = 0; i < shadow_fill[l]; i++) gather.push_back(shadow_elem[l][i]);
      if (gather.size() == 0) push_status(mls_pkg::ST_ALL_EMPTY);
      else push_list(gather, w.action == mls_pkg::ACT_ALL_SRT);
      return;
    end
    if (int'(w.list_number) < 1 || int'(w.list_number) > NL) begin
      push_status(mls_pkg::ST_BAD_LIST);
      return;
    end
    li = int'(w.list_number) - 1;
    fill = shadow_fill[li];
    if (w.action == mls_pkg::ACT_CREATE) begin
      if (shadow_cap[li] != 0) push_status(mls_pkg::ST_EXISTS);
      else if (amt < 1) push_status(mls_pkg::ST_BAD_SIZE);
      else if (amt > LC) push_status(mls_pkg::ST_NO_MEM);
      else begin
        shadow_cap[li] = amt;
        shadow_fill[li] = 0;
        push_status(mls_pkg::ST_OK);
      end
      return;
    end
    if (shadow_cap[li] == 0) begin
      push_status(mls_pkg::ST_NO_LIST);
      return;
    end
    case (w.action)
      mls_pkg::ACT_APPEND: begin
        if (fill >= shadow_cap[li]) push_status(mls_pkg::ST_FULL);
        else begin
          shadow_elem[li][fill] = w.value;
          shadow_fill[li] = fill + 1;
          push_status(mls_pkg::ST_OK);
        end
      end
      mls_pkg::ACT_DROP: begin
        if (fill == 0) push_status(mls_pkg::ST_EMPTY);
        else begin
          shadow_fill[li] = fill - 1;
          push_status(mls_pkg::ST_OK);
        end
      end
      mls_pkg::ACT_DELETE: begin
        hit = 1'b0;
        if (fill == 0) push_status(mls_pkg::ST_EMPTY);
        else begin
          for (int i = 0; i < fill; i++)
            if (!hit && shadow_elem[li][i] == w.value) begin
              hit = 1'b1;
              for (int k = i; k + 1 < fill; k++) shadow_elem[li][k] = shadow_elem[li][k + 1];
              shadow_fill[li] = fill - 1;
            end
          push_status(hit ? mls_pkg::ST_OK : mls_pkg::ST_NOT_FOUND);
        end
      end
      mls_pkg::ACT_READ, mls_pkg::ACT_READ_SRT: begin
        for (int i = 0; i < fill; i++) gather.push_back(shadow_elem[li][i]);
        push_list(gather, w.action == mls_pkg::ACT_READ_SRT);
      end
      mls_pkg::ACT_RESIZE: begin
        ns = int'(shadow_cap[li]) + amt;
        if (ns < 1) push_status(mls_pkg::ST_BAD_NEW_SIZE);
        else if (ns > LC) push_status(mls_pkg::ST_NO_MEM);
        else begin
          shadow_cap[li] = ns;
          if (fill > ns) shadow_fill[li] = ns;
          push_status(mls_pkg::ST_OK);
        end
      end
      default: begin
        if (fill == 0) push_status(mls_pkg::ST_EMPTY);
        else push_answer(mls_pkg::ST_OK, '0, 1'b0, fill[3:0], 1'b1);
      end
    endcase
  endfunction

  // small value pool so deletes hit often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom();
      default: return $urandom_range(0, 7) - 3;
    endcase
  endfunction

  task automatic add_cmd(logic [3:0] act, logic [3:0] num, logic [31:0] val, logic [5:0] amt);
    mls_tb_pkg::pending_cmd_t p;
    p.word.action = act; p.word.list_number = num; p.word.value = val; p.word.size_amount = amt;
    p.wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    cmd_queue.push_back(p);
  endtask

  function automatic logic [3:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return mls_pkg::ACT_CREATE;
    if (r < 38) return mls_pkg::ACT_APPEND;
    if (r < 46) return mls_pkg::ACT_DROP;
    if (r < 58) return mls_pkg::ACT_DELETE;
    if (r < 66) return mls_pkg::ACT_READ;
    if (r < 74) return mls_pkg::ACT_READ_SRT;
    if (r < 82) return mls_pkg::ACT_RESIZE;
    if (r < 88) return mls_pkg::ACT_COUNT;
    if (r < 92) return mls_pkg::ACT_ALL;
    if (r < 96) return mls_pkg::ACT_ALL_SRT;
    return 4'($urandom_range(10, 15));
  endfunction

  // input acceptance, seen at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      predict_store(in_ch.word);
      cmds_sent++;
    end
  end

  // driver
  int unsigned gap_left = 0;
  bit          have_word = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.word  <= '0;
    end else begin
      if (in_taken) have_word = 1'b0;
      if (!have_word && cmd_queue.size() != 0) begin
        if (gap_left == 0) gap_left = cmd_queue[0].wait_cycles + 1;
        gap_left--;
        if (gap_left == 0) begin
          in_ch.word <= cmd_queue.pop_front().word;
          have_word = 1'b1;
        end
      end
      in_ch.valid <= have_word;
    end
  end

  // monitor and receiver back-pressure
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %p", $time, out_ch.word);
      end else if (answers_due[0] !== out_ch.word) begin
        errors++;
        $display("%0t: expected %p actual %p", $time, answers_due[0], out_ch.word);
        void'(answers_due.pop_front());
      end else void'(answers_due.pop_front());
    end
  end
  always @(negedge clk) begin
    if (hold_req && hold_count < HoldLen) begin
      hold_count++;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(0, 5);
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || have_word || in_ch.valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed: errors, extremes, every command
    add_cmd(mls_pkg::ACT_ALL, 4'd0, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_ALL_SRT, 4'd0, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_CREATE, 4'd0, 32'd0, 6'd3);
    add_cmd(mls_pkg::ACT_CREATE, 4'd9, 32'd0, 6'd3);
    add_cmd(mls_pkg::ACT_APPEND, 4'd1, 32'd5, 6'd0);
    add_cmd(mls_pkg::ACT_CREATE, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_CREATE, 4'd1, 32'd0, 6'h20);
    add_cmd(mls_pkg::ACT_CREATE, 4'd1, 32'd0, 6'd9);
    add_cmd(mls_pkg::ACT_CREATE, 4'd1, 32'd0, 6'd2);
    add_cmd(mls_pkg::ACT_CREATE, 4'd1, 32'd0, 6'd2);
    add_cmd(mls_pkg::ACT_DROP, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_DELETE, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_COUNT, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_READ, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_APPEND, 4'd1, 32'h7fff_ffff, 6'd0);
    add_cmd(mls_pkg::ACT_APPEND, 4'd1, 32'h8000_0000, 6'd0);
    add_cmd(mls_pkg::ACT_APPEND, 4'd1, 32'd1, 6'd0);
    add_cmd(mls_pkg::ACT_READ_SRT, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_DELETE, 4'd1, 32'd9, 6'd0);
    add_cmd(mls_pkg::ACT_RESIZE, 4'd1, 32'd0, 6'h30);
    add_cmd(mls_pkg::ACT_RESIZE, 4'd1, 32'd0, 6'd7);
    add_cmd(mls_pkg::ACT_RESIZE, 4'd1, 32'd0, 6'd6);
    add_cmd(mls_pkg::ACT_RESIZE, 4'd1, 32'd0, 6'h39);
    add_cmd(mls_pkg::ACT_COUNT, 4'd1, 32'd0, 6'd0);
    add_cmd(mls_pkg::ACT_ALL_SRT, 4'd0, 32'd0, 6'd0);
    add_cmd(4'd15, 4'd1, 32'd0, 6'd0);
    wait_drained();
    // long receiver hold-off while the sender keeps going
    hold_req = 1'b1;
    add_cmd(mls_pkg::ACT_CREATE, 4'd8, 32'd0, 6'd8);
    for (int i = 0; i < 8; i++) add_cmd(mls_pkg::ACT_APPEND, 4'd8, pick_value(), 6'd0);
    for (int i = 0; i < 6; i++) add_cmd(mls_pkg::ACT_READ, 4'd8, 32'd0, 6'd0);
    wait (hold_count == HoldLen);
    hold_req = 1'b0;
    wait_drained();
    // random
    for (int n = 0; n < 330; n++) begin
      add_cmd(pick_action(), ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
              : 4'($urandom_range(1, NL)), pick_value(),
              ($urandom_range(0, 4) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 5) - 2));
      if (n % 110 == 109) wait_drained();
    end
    wait_drained();
    $display("Ran %0d commands, %0d answer words compared, across bad lists, full and empty lists,",
             cmds_sent, words_checked);
    $display("resizes, deletes and sorted reads of single lists and of the whole store.");
    if (errors == 0) $display("PASS multi_list_store");
    else $display("FAIL multi_list_store");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL multi_list_store");
    $finish;
  end
endmodule

>>> multi_list_store.f
+incdir+design
design/mls_pkg.sv
design/mls_if.sv
design/mls_datapath.sv
design/mls_ctrl.sv
design/multi_list_store.sv
sim/mls_tb_pkg.sv
sim/multi_list_store_test.sv
